@@ src/tgce_pkg.sv @@
`timescale 1ns / 1ps
package tgce_pkg;

    localparam int MAX_BEATS = 48;
    localparam int PAGE_COLS = 4000;
    localparam int STOP_BEATS = 8;

    localparam logic [1:0] OP_GLYPH = 2'd0;
    localparam logic [1:0] OP_PAGE  = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [7:0] B_RAIL_LO  = 8'o101;
    localparam logic [7:0] B_RAIL_UP  = 8'o102;
    localparam logic [7:0] B_MAG_UP   = 8'o103;
    localparam logic [7:0] B_MAG_LO   = 8'o104;
    localparam logic [7:0] B_CASE_LO  = 8'o105;
    localparam logic [7:0] B_CASE_UP  = 8'o106;
    localparam logic [7:0] B_ESC_FWD  = 8'o107;
    localparam logic [7:0] B_ESC_BACK = 8'o110;
    localparam logic [7:0] B_STOP     = 8'o111;
    localparam logic [7:0] B_LEAD_FWD = 8'o112;
    localparam logic [7:0] B_LEAD_BACK = 8'o114;
    localparam logic [7:0] B_PAGE     = 8'o115;
    localparam logic [7:0] B_LEAD_EXT = 8'o116;
    localparam logic [7:0] B_LEAD_MAX = 8'o140;
    localparam logic [7:0] B_ESC_MAX  = 8'o200;
    localparam logic [3:0] B_SIZE_HI  = 4'b0101;

    localparam logic [11:0] ESC_CHUNK  = 12'd127;
    localparam logic [11:0] SIZE_ADJ   = 12'd55;
    localparam logic [12:0] LEAD_CHUNK = 13'd31;
    localparam logic [12:0] LEAD_EXT_MIN = 13'd64;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_RAIL, S_MAG, S_SIZE, S_ESC_DIR, S_ESC_RUN, S_CASE,
        S_LEAD_SET, S_LEAD_DIR, S_LEAD_EXT, S_LEAD_CNT, S_LEAD_RUN, S_COL,
        S_BACK, S_CODE, S_PRST, S_STOP, S_FLUSH
    } state_t;

    typedef enum logic [4:0] {
        C_NONE, C_LOAD, C_RAIL, C_MAG, C_SIZE, C_TOGGLE, C_ESC_CHUNK, C_ESC_LAST,
        C_CASE, C_LEAD_SET, C_LEAD_DIR, C_LEAD_EXT, C_LEAD_CNT, C_LEAD_CHUNK,
        C_LEAD_LAST, C_COL_SET, C_CODE, C_PRST, C_STOP, C_FLUSH
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       col_ok;
        logic       rail_diff;
        logic       mag_diff;
        logic       size_diff;
        logic       case_diff;
        logic       row_diff;
        logic       col_diff;
        logic       back_diff;
        logic       esc_toggle;
        logic       esc_gt;
        logic       esc_nz;
        logic       lead_dir;
        logic       lead_ext;
        logic       lead_gt;
        logic       lead_nz;
        logic       slot_ok;
    } status_t;

    function automatic logic big_size(input logic [3:0] c);
        return (c >= 4'd9) && (c <= 4'd14);
    endfunction

endpackage

@@ src/tgce_ctrl.sv @@
`timescale 1ns / 1ps
module tgce_ctrl
    import tgce_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic       esc_col_reg, esc_col_next;
    logic [2:0] stop_cnt_reg, stop_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            esc_col_reg  <= 1'b0;
            stop_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            esc_col_reg  <= esc_col_next;
            stop_cnt_reg <= stop_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        esc_col_next  = esc_col_reg;
        stop_cnt_next = stop_cnt_reg;
        cmd           = C_NONE;
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd        = C_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            default: begin
                if (st.slot_ok) begin
                    case (state_reg)
                        S_DISPATCH: begin
                            stop_cnt_next = '0;
                            case (st.op)
                                OP_GLYPH: state_next = st.col_ok ? S_RAIL : S_FLUSH;
                                OP_PAGE:  state_next = S_PRST;
                                OP_STOP:  state_next = S_STOP;
                                default:  state_next = S_FLUSH;
                            endcase
                        end
                        S_RAIL: begin
                            if (st.rail_diff) cmd = C_RAIL;
                            state_next = S_MAG;
                        end
                        S_MAG: begin
                            if (st.mag_diff) cmd = C_MAG;
                            state_next = S_SIZE;
                        end
                        S_SIZE: begin
                            if (st.size_diff) begin
                                cmd          = C_SIZE;
                                esc_col_next = 1'b0;
                                state_next   = S_ESC_DIR;
                            end else begin
                                state_next = S_CASE;
                            end
                        end
                        S_ESC_DIR: begin
                            if (st.esc_toggle) cmd = C_TOGGLE;
                            state_next = S_ESC_RUN;
                        end
                        S_ESC_RUN: begin
                            if (st.esc_gt) begin
                                cmd = C_ESC_CHUNK;
                            end else begin
                                if (st.esc_nz) cmd = C_ESC_LAST;
                                state_next = esc_col_reg ? S_BACK : S_CASE;
                            end
                        end
                        S_CASE: begin
                            if (st.case_diff) cmd = C_CASE;
                            state_next = S_LEAD_SET;
                        end
                        S_LEAD_SET: begin
                            if (st.row_diff) begin
                                cmd        = C_LEAD_SET;
                                state_next = S_LEAD_DIR;
                            end else begin
                                state_next = S_COL;
                            end
                        end
                        S_LEAD_DIR: begin
                            if (st.lead_dir) cmd = C_LEAD_DIR;
                            state_next = S_LEAD_EXT;
                        end
                        S_LEAD_EXT: begin
                            if (st.lead_ext) begin
                                cmd        = C_LEAD_EXT;
                                state_next = S_LEAD_CNT;
                            end else begin
                                state_next = S_LEAD_RUN;
                            end
                        end
                        S_LEAD_CNT: begin
                            cmd        = C_LEAD_CNT;
                            state_next = S_LEAD_RUN;
                        end
                        S_LEAD_RUN: begin
                            if (st.lead_gt) begin
                                cmd = C_LEAD_CHUNK;
                            end else begin
                                if (st.lead_nz) cmd = C_LEAD_LAST;
                                state_next = S_COL;
                            end
                        end
                        S_COL: begin
                            if (st.col_diff) begin
                                cmd          = C_COL_SET;
                                esc_col_next = 1'b1;
                                state_next   = S_ESC_DIR;
                            end else begin
                                state_next = S_BACK;
                            end
                        end
                        S_BACK: begin
                            if (st.back_diff) cmd = C_TOGGLE;
                            state_next = S_CODE;
                        end
                        S_CODE: begin
                            cmd        = C_CODE;
                            state_next = S_FLUSH;
                        end
                        S_PRST: begin
                            cmd        = C_PRST;
                            state_next = S_FLUSH;
                        end
                        S_STOP: begin
                            cmd           = C_STOP;
                            stop_cnt_next = stop_cnt_reg + 3'd1;
                            if (stop_cnt_reg == 3'(STOP_BEATS - 1)) state_next = S_FLUSH;
                        end
                        S_FLUSH: begin
                            cmd        = C_FLUSH;
                            state_next = S_IDLE;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
        endcase
    end

endmodule

@@ src/tgce_datapath.sv @@
`timescale 1ns / 1ps
module tgce_datapath
    import tgce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic [1:0]  in_op,
    input  logic [5:0]  in_code,
    input  logic [3:0]  in_size,
    input  logic [11:0] in_col,
    input  logic [12:0] in_row,
    input  logic [1:0]  in_rm,
    input  logic        in_uc,
    input  logic        in_bk,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    // item payload
    logic [1:0]  op_reg;
    logic [5:0]  code_reg;
    logic [3:0]  size_reg;
    logic [11:0] col_reg;
    logic [12:0] row_reg;
    logic [1:0]  rm_reg;
    logic        uc_reg, bk_reg;

    // typesetter state
    logic [12:0] ref_row_reg, ref_row_next;
    logic [11:0] ref_col_reg, ref_col_next;
    logic [1:0]  cur_rm_reg, cur_rm_next;
    logic [3:0]  cur_size_reg, cur_size_next;
    logic        cur_case_reg, cur_case_next;
    logic        cur_back_reg, cur_back_next;
    logic        cur_lead_back_reg, cur_lead_back_next;
    logic        seen_reg, seen_next;

    // work registers
    logic [11:0] esc_mag_reg, esc_mag_next;
    logic        esc_neg_reg, esc_neg_next;
    logic [12:0] lmag_reg, lmag_next;
    logic        lneg_reg, lneg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    logic        emit, emit_ok, load_out, old_big, new_big;
    logic [7:0]  byte_val;
    logic [13:0] lead_d;
    logic [12:0] esc_e;

    assign lead_d = {row_reg[12], row_reg} - {ref_row_reg[12], ref_row_reg};
    assign esc_e  = {1'b0, col_reg} - {1'b0, ref_col_reg};
    assign old_big = big_size(cur_size_reg);
    assign new_big = big_size(size_reg);

    always_comb begin
        st.op         = op_reg;
        st.col_ok     = col_reg < 12'(PAGE_COLS);
        st.rail_diff  = rm_reg[0] != cur_rm_reg[0];
        st.mag_diff   = rm_reg[1] != cur_rm_reg[1];
        st.size_diff  = size_reg != cur_size_reg;
        st.case_diff  = uc_reg != cur_case_reg;
        st.row_diff   = row_reg != ref_row_reg;
        st.col_diff   = col_reg != ref_col_reg;
        st.back_diff  = bk_reg != cur_back_reg;
        st.esc_toggle = esc_neg_reg != cur_back_reg;
        st.esc_gt     = esc_mag_reg > ESC_CHUNK;
        st.esc_nz     = esc_mag_reg != '0;
        st.lead_dir   = lneg_reg != cur_lead_back_reg;
        st.lead_ext   = lmag_reg > LEAD_EXT_MIN;
        st.lead_gt    = lmag_reg > LEAD_CHUNK;
        st.lead_nz    = lmag_reg != '0;
        st.slot_ok    = !out_valid_reg || m_tready;
    end

    always_comb begin
        ref_row_next       = ref_row_reg;
        ref_col_next       = ref_col_reg;
        cur_rm_next        = cur_rm_reg;
        cur_size_next      = cur_size_reg;
        cur_case_next      = cur_case_reg;
        cur_back_next      = cur_back_reg;
        cur_lead_back_next = cur_lead_back_reg;
        seen_next          = seen_reg;
        esc_mag_next       = esc_mag_reg;
        esc_neg_next       = esc_neg_reg;
        lmag_next          = lmag_reg;
        lneg_next          = lneg_reg;
        emit               = 1'b0;
        byte_val           = '0;
        case (cmd)
            C_RAIL: begin
                emit = 1'b1;
                byte_val = rm_reg[0] ? B_RAIL_UP : B_RAIL_LO;
            end
            C_MAG: begin
                emit = 1'b1;
                byte_val = rm_reg[1] ? B_MAG_UP : B_MAG_LO;
            end
            C_SIZE: begin
                emit = 1'b1;
                byte_val = {B_SIZE_HI, size_reg};
                // crossing the large-size group shifts the baseline by 55 units
                esc_neg_next = old_big && !new_big;
                esc_mag_next = (old_big != new_big) ? SIZE_ADJ : '0;
            end
            C_TOGGLE: begin
                emit = 1'b1;
                byte_val = cur_back_reg ? B_ESC_FWD : B_ESC_BACK;
                cur_back_next = !cur_back_reg;
            end
            C_ESC_CHUNK: begin
                emit = 1'b1;
                byte_val = B_ESC_MAX;
                esc_mag_next = esc_mag_reg - ESC_CHUNK;
            end
            C_ESC_LAST: begin
                emit = 1'b1;
                byte_val = {1'b1, ~esc_mag_reg[6:0]};
                esc_mag_next = '0;
            end
            C_CASE: begin
                emit = 1'b1;
                byte_val = uc_reg ? B_CASE_UP : B_CASE_LO;
            end
            C_LEAD_SET: begin
                lneg_next = lead_d[13];
                lmag_next = lead_d[13] ? 13'(-lead_d) : lead_d[12:0];
            end
            C_LEAD_DIR: begin
                emit = 1'b1;
                byte_val = lneg_reg ? B_LEAD_BACK : B_LEAD_FWD;
                cur_lead_back_next = lneg_reg;
            end
            C_LEAD_EXT: begin
                emit = 1'b1;
                byte_val = B_LEAD_EXT;
            end
            C_LEAD_CNT: begin
                emit = 1'b1;
                byte_val = {1'b0, lmag_reg[12:6]};
                lmag_next = {7'd0, lmag_reg[5:0]};
            end
            C_LEAD_CHUNK: begin
                emit = 1'b1;
                byte_val = B_LEAD_MAX;
                lmag_next = lmag_reg - LEAD_CHUNK;
            end
            C_LEAD_LAST: begin
                emit = 1'b1;
                byte_val = {B_LEAD_MAX[7:5], ~lmag_reg[4:0]};
                lmag_next = '0;
            end
            C_COL_SET: begin
                esc_neg_next = esc_e[12];
                esc_mag_next = esc_e[12] ? 12'(-esc_e) : esc_e[11:0];
            end
            C_CODE: begin
                emit = 1'b1;
                byte_val = {2'b00, code_reg};
                ref_row_next  = row_reg;
                ref_col_next  = col_reg;
                cur_rm_next   = rm_reg;
                cur_size_next = size_reg;
                cur_case_next = uc_reg;
                cur_back_next = bk_reg;
            end
            C_PRST: begin
                emit = seen_reg;
                byte_val = B_PAGE;
                seen_next = 1'b1;
                ref_row_next = '0;
                ref_col_next = '0;
            end
            C_STOP: begin
                emit = 1'b1;
                byte_val = B_STOP;
            end
            default: ;
        endcase
    end

    // one beat is held back so the final one can carry tlast
    always_comb begin
        emit_ok         = emit && (cnt_reg < 6'(MAX_BEATS));
        load_out        = pend_valid_reg && (emit_ok || cmd == C_FLUSH);
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_byte_next  = pend_byte_reg;
            out_last_next  = (cmd == C_FLUSH);
        end
        if (emit_ok) begin
            cnt_next        = cnt_reg + 6'd1;
            pend_valid_next = 1'b1;
            pend_byte_next  = byte_val;
        end
        if (cmd == C_FLUSH) begin
            cnt_next        = '0;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd == C_LOAD) begin
            op_reg   <= in_op;
            code_reg <= in_code;
            size_reg <= in_size;
            col_reg  <= in_col;
            row_reg  <= in_row;
            rm_reg   <= in_rm;
            uc_reg   <= in_uc;
            bk_reg   <= in_bk;
        end
        esc_mag_reg   <= esc_mag_next;
        esc_neg_reg   <= esc_neg_next;
        lmag_reg      <= lmag_next;
        lneg_reg      <= lneg_next;
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_row_reg       <= '0;
            ref_col_reg       <= '0;
            cur_rm_reg        <= '0;
            cur_size_reg      <= 4'd2;
            cur_case_reg      <= 1'b0;
            cur_back_reg      <= 1'b0;
            cur_lead_back_reg <= 1'b0;
            seen_reg          <= 1'b0;
            cnt_reg           <= '0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            ref_row_reg       <= ref_row_next;
            ref_col_reg       <= ref_col_next;
            cur_rm_reg        <= cur_rm_next;
            cur_size_reg      <= cur_size_next;
            cur_case_reg      <= cur_case_next;
            cur_back_reg      <= cur_back_next;
            cur_lead_back_reg <= cur_lead_back_next;
            seen_reg          <= seen_next;
            cnt_reg           <= cnt_next;
            pend_valid_reg    <= pend_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ src/typesetter_glyph_code_encoder_core.sv @@
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                              | tuser     | tlast
// s_      | in  | char_code 6, size_code 4, column 12, row 13,   | operation | -
//         |     | rail_mag 2, upper_case 1, backward 1, pad 1     |           |
// m_      | out | code_byte 8                                     | -         | last
// One item at a time: accept, dispatch, then one controller step per check or per
// emitted byte, plus a final flush step. A glyph adds steps for size, row and column
// changes and for each full escape or leading chunk; a stop trailer emits its stop
// bytes, and an off-page glyph or unused op goes straight to the flush step.
// A controller step waits while the output register holds an untaken beat.
// aresetn is synchronous; reset sets size code 2, clears positions, modes and flags.
module typesetter_glyph_code_encoder_core
    import tgce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // char_code, size_code, column, row, rail_mag,
                                   // upper_case, backward, zero pad
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // code_byte
    output logic        m_tlast
);

    status_t st;
    cmd_t    cmd;

    tgce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tgce_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .in_op    (s_tuser),
        .in_code  (s_tdata[5:0]),
        .in_size  (s_tdata[9:6]),
        .in_col   (s_tdata[21:10]),
        .in_row   (s_tdata[34:22]),
        .in_rm    (s_tdata[36:35]),
        .in_uc    (s_tdata[37]),
        .in_bk    (s_tdata[38]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/tgce_checker.sv @@
`timescale 1ns / 1ps
module tgce_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is at work");

    a_no_early_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("output beat appeared right after accept");

endmodule

bind typesetter_glyph_code_encoder_core tgce_checker u_tgce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
